// ----- sv/pcmspm_pkg.sv -----
// ----------------------------------------------------------------------------
// PCM sample player package
// Shared types and constants for the sixteen-voice PCM sample player.
// ----------------------------------------------------------------------------
package pcmspm_pkg;

  typedef enum logic [1:0] {
    KIND_REG_WRITE = 2'd0,
    KIND_SEEK      = 2'd1,
    KIND_UPLOAD    = 2'd2,
    KIND_RENDER    = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_BANK_SHIFT  = 2'd0;
  localparam logic [1:0] CFG_BANK_MASK   = 2'd1;
  localparam logic [1:0] CFG_WINDOW_BASE = 2'd2;

  localparam logic [7:0] REG_RESET     = 8'hFF;
  localparam logic [7:0] ROM_SILENCE   = 8'h80;
  localparam logic [7:0] HIGH_BASE     = 8'h84;
  localparam logic [4:0] SHIFT_RESET   = 5'd12;
  localparam logic [7:0] MASK_RESET    = 8'h70;
  localparam logic signed [11:0] SAMPLE_MAX = 12'sd2047;
  localparam logic signed [11:0] SAMPLE_MIN = -12'sd2048;

endpackage

// ----- sv/pcm_sample_playback_mixer_top.sv -----
// ----------------------------------------------------------------------------
// PCM sample playback mixer
// Sixteen-voice 8-bit PCM sample player with register RAM and sample ROM.
//
// Items enter on s_axis (tdata: kind[1:0], reg_index[9:2], data_byte[17:10]).
// Register writes, seeks and uploads give no result. A render item walks the
// channels and gives one 12-bit signed sample on m_axis.
// Configuration writes (index 0 bank shift, 1 bank mask, 2 window base) use
// the cfg channel and are taken in any cycle.
// After reset the block clears the register RAM to 0xFF and the sample ROM
// to 0x80 in a single pass, during which no item is accepted.
// A render walks the channels in turn through the single register RAM port,
// from which each channel reads and writes back one byte at a time.
// The result waits in an output register; a new item is accepted while it
// waits, but a render does not finish until the earlier result is taken.
// ----------------------------------------------------------------------------
module pcm_sample_playback_mixer_top #(
  parameter int ROM_BYTES = 131072,
  parameter int CHANNELS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // kind[1:0], reg_index[9:2], data_byte[17:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample[11:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pcmspm_pkg::*;

  localparam int RAW = $clog2(ROM_BYTES);
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CTRL, ST_CTRL_W, ST_AH, ST_AH_W, ST_AM, ST_AM_W,
    ST_EP, ST_EP_W, ST_L4, ST_L4_W, ST_L5, ST_L5_W, ST_ROM, ST_ROM_W,
    ST_VL, ST_VL_W, ST_VR, ST_VR_W, ST_DL, ST_DL_W, ST_WB_H, ST_WB_M,
    ST_WB_C, ST_NEXT, ST_DONE
  } state_t;

  state_t state;

  logic [7:0]     reg_ram [256];
  logic [7:0]     frac_ram [16];
  logic [7:0]     rom [ROM_BYTES];
  logic [7:0]     reg_rd;
  logic [7:0]     rom_rd;
  logic [7:0]     reg_addr;
  logic [7:0]     reg_wdata;
  logic           reg_we;
  logic [RAW-1:0] rom_waddr;
  logic [RAW-1:0] rom_raddr;
  logic [7:0]     rom_wdata;
  logic           rom_we;

  logic [4:0]     bank_shift;
  logic [7:0]     bank_mask;
  logic [15:0]    window_base;
  logic [RAW:0]   cursor;
  logic [RAW:0]   clr_cnt;

  logic [1:0]     kind;
  logic [7:0]     reg_index;
  logic [7:0]     data_byte;
  logic [CW-1:0]  ch;
  logic [7:0]     ctrl;
  logic [23:0]    addr;
  logic [7:0]     endp;
  logic [7:0]     loop_lo;
  logic           rom_in;
  logic signed [8:0]  v;
  logic signed [20:0] mix;
  logic signed [11:0] sample_out;

  logic [7:0]     lo_base;
  logic [7:0]     hi_base;
  logic [39:0]    idx;
  logic [39:0]    wbase;
  logic [39:0]    rel;
  logic [31:0]    seek_abs;
  logic [31:0]    seek_base;
  logic [31:0]    seek_rel;
  logic [8:0]     endp1;
  logic signed [20:0] mix_sh;
  logic [23:0]    addr_sum;

  assign lo_base  = {ch[CW-1:0] , 3'b000} & 8'hFF;
  assign hi_base  = HIGH_BASE + lo_base;
  assign idx      = ({32'd0, ctrl & bank_mask} << bank_shift) | {24'd0, addr[23:8]};
  assign wbase    = {16'd0, window_base, 8'd0};
  assign rel      = idx - wbase;
  assign seek_abs  = {8'd0, reg_index, data_byte, 8'd0};
  assign seek_base = {8'd0, window_base, 8'd0};
  assign seek_rel  = seek_abs - seek_base;
  assign endp1    = {1'b0, endp} + 9'd1;
  assign mix_sh   = mix >>> 4;
  assign addr_sum = addr + {16'd0, reg_rd};

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {4'd0, sample_out};

  always_ff @(posedge clk) begin
    if (reg_we) begin
      reg_ram[reg_addr] <= reg_wdata;
    end
    reg_rd <= reg_ram[reg_addr];
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom[rom_waddr] <= rom_wdata;
    end
    rom_rd <= rom[rom_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_shift  <= SHIFT_RESET;
      bank_mask   <= MASK_RESET;
      window_base <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BANK_SHIFT:  bank_shift  <= cfg_data[4:0];
        CFG_BANK_MASK:   bank_mask   <= cfg_data[7:0];
        CFG_WINDOW_BASE: window_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    reg_we    = 1'b0;
    reg_wdata = 8'd0;
    reg_addr  = 8'd0;
    rom_we    = 1'b0;
    rom_waddr = clr_cnt[RAW-1:0];
    rom_wdata = ROM_SILENCE;
    rom_raddr = rel[RAW-1:0];
    case (state)
      ST_CLEAR: begin
        rom_we = 1'b1;
        reg_we = 1'b1;
        reg_addr = clr_cnt[7:0];
        reg_wdata = REG_RESET;
      end
      ST_CTRL:  reg_addr = hi_base + 8'd2;
      ST_AH:    reg_addr = hi_base + 8'd1;
      ST_AM:    reg_addr = hi_base;
      ST_EP:    reg_addr = lo_base + 8'd6;
      ST_L4:    reg_addr = lo_base + 8'd4;
      ST_L5:    reg_addr = lo_base + 8'd5;
      ST_VL:    reg_addr = lo_base + 8'd2;
      ST_VR:    reg_addr = lo_base + 8'd3;
      ST_DL:    reg_addr = lo_base + 8'd7;
      ST_WB_H: begin
        reg_we = 1'b1;
        reg_addr = hi_base;
        reg_wdata = addr[15:8];
      end
      ST_WB_M: begin
        reg_we = 1'b1;
        reg_addr = hi_base + 8'd1;
        reg_wdata = addr[23:16];
      end
      ST_WB_C: begin
        reg_we = 1'b1;
        reg_addr = hi_base + 8'd2;
        reg_wdata = ctrl | 8'd1;
      end
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tdata[1:0] == KIND_REG_WRITE) begin
          reg_we = 1'b1;
          reg_addr = s_axis_tdata[9:2];
          reg_wdata = s_axis_tdata[17:10];
        end
        if (s_axis_tvalid && s_axis_tdata[1:0] == KIND_UPLOAD &&
            cursor < (RAW+1)'(ROM_BYTES)) begin
          rom_we = 1'b1;
          rom_waddr = cursor[RAW-1:0];
          rom_wdata = s_axis_tdata[17:10];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      cursor        <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        frac_ram[i] <= 8'd0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready && !(state == ST_DONE && kind != KIND_SEEK)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (RAW+1)'(ROM_BYTES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            kind      <= s_axis_tdata[1:0];
            reg_index <= s_axis_tdata[9:2];
            data_byte <= s_axis_tdata[17:10];
            case (s_axis_tdata[1:0])
              KIND_UPLOAD: if (cursor < (RAW+1)'(ROM_BYTES)) cursor <= cursor + 1'b1;
              KIND_SEEK:   state <= ST_DONE;
              KIND_RENDER: begin
                ch    <= '0;
                mix   <= '0;
                state <= ST_CTRL;
              end
              default: ;
            endcase
          end
        end
        ST_DONE: begin
          if (kind == KIND_SEEK) begin
            if (seek_abs >= seek_base && seek_rel < 32'(ROM_BYTES)) begin
              cursor <= seek_rel[RAW:0];
            end else begin
              cursor <= (RAW+1)'(ROM_BYTES);
            end
            state <= ST_IDLE;
          end else if (!m_axis_tvalid || m_axis_tready) begin
            if (mix_sh > 21'(SAMPLE_MAX)) begin
              sample_out <= SAMPLE_MAX;
            end else if (mix_sh < 21'(SAMPLE_MIN)) begin
              sample_out <= SAMPLE_MIN;
            end else begin
              sample_out <= mix_sh[11:0];
            end
            m_axis_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_CTRL:   state <= ST_CTRL_W;
        ST_CTRL_W: begin
          ctrl <= reg_rd;
          addr[7:0] <= frac_ram[4'(ch)];
          state <= reg_rd[0] ? ST_NEXT : ST_AH;
        end
        ST_AH:     state <= ST_AH_W;
        ST_AH_W: begin
          addr[23:16] <= reg_rd;
          state <= ST_AM;
        end
        ST_AM:     state <= ST_AM_W;
        ST_AM_W: begin
          addr[15:8] <= reg_rd;
          state <= ST_EP;
        end
        ST_EP:     state <= ST_EP_W;
        ST_EP_W: begin
          endp  <= reg_rd;
          state <= ST_L4;
        end
        ST_L4:     state <= ST_L4_W;
        ST_L4_W: begin
          loop_lo <= reg_rd;
          state   <= ST_L5;
        end
        ST_L5:     state <= ST_L5_W;
        ST_L5_W: begin
          if ({1'b0, addr[23:16]} == endp1) begin
            if (ctrl[1]) begin
              state <= ST_WB_C;
            end else begin
              addr  <= {reg_rd, loop_lo, 8'd0};
              state <= ST_ROM;
            end
          end else begin
            state <= ST_ROM;
          end
        end
        ST_ROM: begin
          rom_in <= (idx >= wbase) && (rel < 40'(ROM_BYTES));
          state  <= ST_ROM_W;
        end
        ST_ROM_W: begin
          v     <= rom_in ? ($signed({1'b0, rom_rd}) - 9'sd128) : 9'sd0;
          state <= ST_VL;
        end
        ST_VL:     state <= ST_VL_W;
        ST_VL_W: begin
          mix   <= mix + 21'(v * $signed({1'b0, reg_rd[6:0]}));
          state <= ST_VR;
        end
        ST_VR:     state <= ST_VR_W;
        ST_VR_W: begin
          mix   <= mix + 21'(v * $signed({1'b0, reg_rd[6:0]}));
          state <= ST_DL;
        end
        ST_DL:     state <= ST_DL_W;
        ST_DL_W: begin
          addr  <= addr_sum;
          frac_ram[4'(ch)] <= addr_sum[7:0];
          state <= ST_WB_H;
        end
        ST_WB_H:   state <= ST_WB_M;
        ST_WB_M:   state <= ST_NEXT;
        ST_WB_C:   state <= ST_NEXT;
        ST_NEXT: begin
          if (32'(ch) == 32'(CHANNELS - 1)) begin
            state <= ST_DONE;
          end else begin
            ch    <= ch + 1'b1;
            state <= ST_CTRL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/pcm_sample_playback_mixer_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM sample player checker
// Watches the item, result and configuration channels, keeps its own copy of
// the register RAM, sample ROM and upload cursor, predicts each rendered
// sample and compares it with the sample that leaves the block.
// ----------------------------------------------------------------------------
module pcm_sample_playback_mixer_check
  import pcmspm_pkg::*;
#(
  parameter int ROM_BYTES = 131072,
  parameter int CHANNELS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          errors,
  output int          render_count,
  output int          upload_count
);

  logic [7:0]  regs [256];
  logic [7:0]  frac [16];
  logic [7:0]  rom [ROM_BYTES];
  logic [31:0] cursor;
  logic [4:0]  shift_q;
  logic [7:0]  mask_q;
  logic [15:0] base_q;
  logic signed [11:0] samples_due [$];

  function automatic logic signed [11:0] render_sample();
    int          mix;
    int          v;
    int          hi;
    int          lo;
    logic [7:0]  ctrl;
    logic [31:0] addr;
    logic [31:0] endp;
    longint      idx;
    longint      base;
    mix = 0;
    base = longint'(base_q) << 8;
    for (int ch = 0; ch < CHANNELS && ch < 16; ch++) begin
      lo = 8 * ch;
      hi = HIGH_BASE + 8 * ch;
      ctrl = regs[hi + 2];
      if (!ctrl[0]) begin
        addr = {8'h00, regs[hi + 1], regs[hi], frac[ch]};
        endp = 32'(regs[lo + 6]) + 1;
        if ((addr >> 16) == endp && ctrl[1]) begin
          regs[hi + 2] = ctrl | 8'h01;
        end else begin
          if ((addr >> 16) == endp) addr = {8'h00, regs[lo + 5], regs[lo + 4], 8'h00};
          idx = (longint'(ctrl & mask_q) << shift_q) | longint'(addr[23:8]);
          v = 0;
          if (idx >= base && idx - base < ROM_BYTES) v = int'(rom[idx - base]) - 128;
          mix += v * int'(regs[lo + 2][6:0]);
          mix += v * int'(regs[lo + 3][6:0]);
          addr = (addr + 32'(regs[lo + 7])) & 32'hFFFFFF;
          regs[hi] = addr[15:8];
          regs[hi + 1] = addr[23:16];
          frac[ch] = addr[7:0];
        end
      end
    end
    mix = mix >>> 4;
    if (mix > 2047) mix = 2047;
    if (mix < -2048) mix = -2048;
    return 12'(mix);
  endfunction

  always @(posedge clk) begin
    logic [1:0]  kind;
    logic [7:0]  rix;
    logic [7:0]  dat;
    logic [31:0] absolute;
    logic [31:0] wbase;
    logic signed [11:0] want;
    if (rst) begin
      foreach (regs[i]) regs[i] = REG_RESET;
      foreach (frac[i]) frac[i] = 8'h00;
      foreach (rom[i]) rom[i] = ROM_SILENCE;
      cursor = 0;
      shift_q = SHIFT_RESET;
      mask_q = MASK_RESET;
      base_q = 16'h0000;
      samples_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (samples_due.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected sample: expected none, actual %0d", $time,
                   $signed(m_axis_tdata[11:0]));
        end else begin
          want = samples_due.pop_front();
          if (m_axis_tdata[11:0] !== want) begin
            errors <= errors + 1;
            $display("%0t: sample mismatch: expected %0d, actual %0d", $time, want,
                     $signed(m_axis_tdata[11:0]));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BANK_SHIFT:  shift_q = cfg_data[4:0];
          CFG_BANK_MASK:   mask_q = cfg_data[7:0];
          CFG_WINDOW_BASE: base_q = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        kind = s_axis_tdata[1:0];
        rix = s_axis_tdata[9:2];
        dat = s_axis_tdata[17:10];
        case (kind)
          KIND_REG_WRITE: regs[rix] = dat;
          KIND_SEEK: begin
            absolute = {8'h00, rix, dat, 8'h00};
            wbase = {8'h00, base_q, 8'h00};
            if (absolute >= wbase && absolute - wbase < ROM_BYTES) cursor = absolute - wbase;
            else cursor = ROM_BYTES;
          end
          KIND_UPLOAD: begin
            upload_count <= upload_count + 1;
            if (cursor < ROM_BYTES) begin
              rom[cursor] = dat;
              cursor = cursor + 1;
            end
          end
          default: begin
            render_count <= render_count + 1;
            samples_due.push_back(render_sample());
          end
        endcase
      end
    end
    pending <= samples_due.size();
  end

  initial begin
    pending = 0;
    errors = 0;
    render_count = 0;
    upload_count = 0;
  end

endmodule

// ----- tb/pcm_sample_playback_mixer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM sample player testbench
// Drives register writes, seeks, ROM uploads and renders with random gaps and
// output stalls across several bank and window settings; the checker predicts
// every sample and counts mismatches.
// ----------------------------------------------------------------------------
module pcm_sample_playback_mixer_top_test;
  import pcmspm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          pending;
  int          errors;
  int          render_count;
  int          upload_count;
  bit          quiet = 1'b0;

  always #5 clk = ~clk;

  pcm_sample_playback_mixer_top dut (.*);
  pcm_sample_playback_mixer_check checker_i (.*);

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_item(kind_t kind, logic [7:0] rix, logic [7:0] dat);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata = {6'b0, dat, rix, kind};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_config(logic [1:0] index, logic [15:0] value);
    drain();
    cfg_index = index;
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_channel(int ch, logic [7:0] vl, logic [7:0] vr, logic [7:0] loop_mid,
                             logic [7:0] endp, logic [7:0] delta, logic [7:0] pos_mid,
                             logic [7:0] addr_hi, logic [7:0] ctrl);
    send_item(KIND_REG_WRITE, 8'(8 * ch + 2), vl);
    send_item(KIND_REG_WRITE, 8'(8 * ch + 3), vr);
    send_item(KIND_REG_WRITE, 8'(8 * ch + 4), loop_mid);
    send_item(KIND_REG_WRITE, 8'(8 * ch + 5), 8'h00);
    send_item(KIND_REG_WRITE, 8'(8 * ch + 6), endp);
    send_item(KIND_REG_WRITE, 8'(8 * ch + 7), delta);
    send_item(KIND_REG_WRITE, 8'(HIGH_BASE + 8 * ch), pos_mid);
    send_item(KIND_REG_WRITE, 8'(HIGH_BASE + 8 * ch + 1), addr_hi);
    send_item(KIND_REG_WRITE, 8'(HIGH_BASE + 8 * ch + 2), ctrl);
  endtask

  task automatic random_round(int budget);
    int          done;
    int          ch;
    int          n;
    logic [7:0]  mid;
    done = 0;
    while (done < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        ch = $urandom_range(0, 15);
        mid = 8'($urandom_range(0, 3));
        set_channel(ch, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 3)), 8'h00,
                    8'($urandom), mid, ($urandom_range(0, 3) == 0) ? 8'h01 : 8'h00,
                    {1'b0, 3'($urandom_range(0, 1)), 2'b00, 1'($urandom), 1'b0});
        send_item(KIND_SEEK, 8'h00, mid);
        n = $urandom_range(1, 8);
        repeat (n) send_item(KIND_UPLOAD, 8'h00, 8'($urandom));
        done += 10 + n;
        repeat ($urandom_range(2, 6)) begin
          send_item(KIND_RENDER, 8'($urandom), 8'($urandom));
          done++;
        end
      end else begin
        send_item(kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;
    // Directed part: reset state, clamping, stop and loop at the end page.
    send_item(KIND_RENDER, 8'h00, 8'h00);
    send_item(KIND_SEEK, 8'h00, 8'h00);
    send_item(KIND_UPLOAD, 8'hFF, 8'hFF);
    send_item(KIND_UPLOAD, 8'h00, 8'h00);
    for (int c = 0; c < 16; c++)
      set_channel(c, 8'hFF, 8'h7F, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(KIND_RENDER, 8'hFF, 8'hFF);
    send_item(KIND_REG_WRITE, 8'h84, 8'h01);
    send_item(KIND_RENDER, 8'h00, 8'h00);
    send_item(KIND_REG_WRITE, 8'h85, 8'h01);
    send_item(KIND_REG_WRITE, 8'h8D, 8'h01);
    send_item(KIND_REG_WRITE, 8'h8E, 8'h02);
    send_item(KIND_RENDER, 8'h00, 8'h00);
    send_item(KIND_RENDER, 8'h00, 8'h00);
    send_item(KIND_SEEK, 8'h02, 8'h00);
    send_item(KIND_UPLOAD, 8'h00, 8'h55);
    send_item(KIND_REG_WRITE, 8'hFF, 8'h00);
    send_item(KIND_SEEK, 8'h01, 8'hFF);
    repeat (258) send_item(KIND_UPLOAD, 8'h00, 8'($urandom));

    random_round(80);
    write_config(CFG_BANK_SHIFT, 16'd0);
    write_config(CFG_BANK_MASK, 16'h00FF);
    quiet = 1'b1;
    random_round(50);
    quiet = 1'b0;
    write_config(CFG_BANK_SHIFT, 16'd23);
    write_config(CFG_BANK_MASK, 16'h0001);
    write_config(CFG_WINDOW_BASE, 16'h0001);
    send_item(KIND_SEEK, 8'h00, 8'h00);
    send_item(KIND_UPLOAD, 8'h00, 8'h11);
    random_round(50);
    write_config(CFG_BANK_SHIFT, 16'hFFFF);
    write_config(CFG_BANK_MASK, 16'h0000);
    write_config(CFG_WINDOW_BASE, 16'hFFFF);
    write_config(2'd3, 16'hFFFF);
    random_round(40);
    write_config(CFG_BANK_SHIFT, 16'(SHIFT_RESET));
    write_config(CFG_BANK_MASK, 16'(MASK_RESET));
    write_config(CFG_WINDOW_BASE, 16'h0000);
    random_round(70);

    drain();
    repeat (200) @(negedge clk);
    $display("Covered %0d renders and %0d ROM uploads over five bank and window settings.",
             render_count, upload_count);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
